// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the congestion window block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Check a same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check a next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/dctcp_pkg.sv =====
// Types, constants and helper functions of the congestion window block.
// No dependencies; imported by every module of the block.
package dctcp_pkg;

  localparam int WINDOW_BITS  = 32;
  localparam int MSS_BITS     = 16;
  localparam int BYTES_BITS   = 32;
  localparam int ECN_BITS     = 16;
  localparam int OUT_WIN_BITS = 32;
  localparam int CALC_BITS    = 64;
  localparam int PROD_BITS    = BYTES_BITS + MSS_BITS;
  localparam int CNT_BITS     = $clog2(PROD_BITS);
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  // Reciprocal of three: (x * RECIP3) >> RECIP3_SHIFT == x / 3 for 32-bit x
  localparam int RECIP3_BITS  = 33;
  localparam int RECIP3_SHIFT = 33;
  localparam logic [RECIP3_BITS-1:0] RECIP3 = 33'h0_AAAA_AAAB;

  localparam logic [WINDOW_BITS-1:0]  WIN_MAX        = '1;
  localparam logic [MSS_BITS-1:0]     MSS_RESET      = 16'd4096;
  localparam logic [DATA_BITS-1:0]    INIT_WIN_RESET = 32'd65536;
  localparam logic [OUT_WIN_BITS-1:0] OUT_WIN_MAX    = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_MSS      = 1'b0;
  localparam logic REG_INIT_WIN = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_NACK = 2'd1,
    ACT_INC  = 2'd2,
    ACT_ECN  = 2'd3
  } action_t;

  typedef struct packed {
    logic                  has_nack;
    logic                  has_ack;
    logic [BYTES_BITS-1:0] nacked_bytes;
    logic [BYTES_BITS-1:0] acked_bytes;
    logic [ECN_BITS-1:0]   ecn_count;
  } in_t;

  typedef struct packed {
    logic [OUT_WIN_BITS-1:0] window_bytes;
    action_t                 action;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic                 idx;
    logic [DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [MSS_BITS-1:0]  mss;
    logic [DATA_BITS-1:0] init_win;
  } cfg_rd_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic update;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_inc;
    logic div_busy;
    logic out_free;
  } status_t;

  // Clamp a value to the window range
  function automatic logic [WINDOW_BITS-1:0] sat_win(input logic [CALC_BITS-1:0] v);
    return (v > CALC_BITS'(WIN_MAX)) ? WIN_MAX : v[WINDOW_BITS-1:0];
  endfunction

  // Clamp the window to the result field
  function automatic logic [OUT_WIN_BITS-1:0] sat_out(input logic [WINDOW_BITS-1:0] w);
    logic [CALC_BITS-1:0] wext;
    wext = CALC_BITS'(w);
    return (wext > CALC_BITS'(OUT_WIN_MAX)) ? OUT_WIN_MAX : wext[OUT_WIN_BITS-1:0];
  endfunction

endpackage

// ===== sv/dctcp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window increase.
// Depends on dctcp_pkg.
module dctcp_div
  import dctcp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PROD_BITS-1:0]   dividend,
  input  logic [WINDOW_BITS-1:0] divisor,
  output logic                   busy,
  output logic [PROD_BITS-1:0]   quotient
);

  logic [PROD_BITS-1:0]   quo;
  logic [WINDOW_BITS-1:0] rem;
  logic [WINDOW_BITS-1:0] dvs;
  logic [CNT_BITS-1:0]    cnt;
  logic [WINDOW_BITS:0]   rem_sh;
  logic                   ge;
  logic [WINDOW_BITS:0]   rem_sub;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem, quo[PROD_BITS-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Control: count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(PROD_BITS - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[PROD_BITS-2:0], ge};
      rem <= ge ? rem_sub[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/dctcp_dp.sv =====
// Datapath: registers, window update arithmetic and result register.
// Depends on dctcp_pkg and dctcp_div.
module dctcp_dp
  import dctcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  output cfg_rd_t cfg_rd,
  input  in_t     in_data,
  input  cmd_t    cmd,
  output status_t status,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  logic [MSS_BITS-1:0]    mss;
  logic [DATA_BITS-1:0]   init_win;
  logic [WINDOW_BITS-1:0] window;
  in_t                    ev;
  logic [BYTES_BITS-1:0]  cut3;

  logic [PROD_BITS-1:0]              prod;
  logic [BYTES_BITS+RECIP3_BITS-1:0] prod3;
  logic [WINDOW_BITS-1:0]            divisor;
  logic [PROD_BITS-1:0]              quo;
  logic                              div_start;

  logic [CALC_BITS-1:0]   w64;
  logic [CALC_BITS-1:0]   mss64;
  logic [CALC_BITS-1:0]   amt64;
  logic [CALC_BITS-1:0]   cut_diff;
  logic [CALC_BITS-1:0]   room;
  logic [CALC_BITS-1:0]   inc64;
  logic [CALC_BITS-1:0]   grown;
  logic [CALC_BITS-1:0]   raw;
  logic [CALC_BITS-1:0]   floored;
  logic [WINDOW_BITS-1:0] win_next;
  action_t                act;

  // Configuration registers; an initial window write reloads the window
  always_ff @(posedge clk) begin
    if (rst) begin
      mss      <= MSS_RESET;
      init_win <= INIT_WIN_RESET;
      window   <= sat_win(CALC_BITS'(INIT_WIN_RESET));
    end else if (cfg_wr.we) begin
      if (cfg_wr.idx == REG_MSS) begin
        mss <= cfg_wr.data[MSS_BITS-1:0];
      end else begin
        init_win <= cfg_wr.data;
        window   <= sat_win(CALC_BITS'(cfg_wr.data));
      end
    end else if (cmd.update) begin
      window <= win_next;
    end
  end

  assign cfg_rd.mss      = mss;
  assign cfg_rd.init_win = init_win;

  // Hold the accepted event
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ev <= in_data;
    end
  end

  // Products: increase numerator and the divide-by-three cut
  assign prod      = PROD_BITS'(ev.acked_bytes) * PROD_BITS'(mss);
  assign prod3     = (BYTES_BITS+RECIP3_BITS)'(ev.acked_bytes)
                     * (BYTES_BITS+RECIP3_BITS)'(RECIP3);
  assign divisor   = (window == '0) ? WINDOW_BITS'(1) : window;
  assign div_start = cmd.mul && status.is_inc;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      cut3 <= BYTES_BITS'(prod3 >> RECIP3_SHIFT);
    end
  end

  dctcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .busy     (status.div_busy),
    .quotient (quo)
  );

  assign status.is_inc   = !ev.has_nack && ev.has_ack && (ev.ecn_count == '0);
  assign status.out_free = !out_valid || out_ready;

  // New window: cut, grow or hold, then floor at mss when an action is taken
  always_comb begin
    w64      = CALC_BITS'(window);
    mss64    = CALC_BITS'(mss);
    amt64    = CALC_BITS'(ev.has_nack ? ev.nacked_bytes : cut3);
    cut_diff = (w64 > amt64) ? (w64 - amt64) : '0;
    room     = CALC_BITS'(WIN_MAX) - w64;
    inc64    = CALC_BITS'(quo);
    grown    = (inc64 > room) ? CALC_BITS'(WIN_MAX) : (w64 + inc64);
    priority if (ev.has_nack) begin
      raw = cut_diff;
      act = ACT_NACK;
    end else if (status.is_inc) begin
      raw = grown;
      act = ACT_INC;
    end else if (ev.has_ack) begin
      raw = cut_diff;
      act = ACT_ECN;
    end else begin
      raw = w64;
      act = ACT_NONE;
    end
    floored  = ((act != ACT_NONE) && (raw < mss64)) ? mss64 : raw;
    win_next = sat_win(floored);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data.window_bytes <= sat_out(win_next);
      out_data.action       <= act;
    end
  end

endmodule

// ===== sv/dctcp_ctrl.sv =====
// Controller state machine that sequences one event through the datapath.
// Depends on dctcp_pkg.
module dctcp_ctrl
  import dctcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through multiply, divide (increases only) and update
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.is_inc ? S_DIV : S_UPD;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/dctcp_window_update_core.sv =====
// Top level of the congestion window block: APB registers, controller, datapath.
// Depends on dctcp_pkg, dctcp_ctrl, dctcp_dp and assert_macros.svh.
//
// Keeps a DCTCP-style congestion window and returns one result (window and
// action) per event transfer. A NACK or ECN cut or a no-op event passes
// through the MUL and UPD states from input transfer to result; an additive
// increase also waits in DIV for the 48-step bit-serial divider that computes
// acked_bytes*mss/window. One event is in work at a time; the result register
// lets the next event be taken while a result waits for out_ready. Registers:
// mss at 0x0, initial_window at 0x4; writing initial_window also reloads the
// window.
`include "assert_macros.svh"

module dctcp_window_update_core
  import dctcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  cfg_wr_t cfg_wr;
  cfg_rd_t cfg_rd;
  cmd_t    cmd;
  status_t status;

  // Decode the APB access
  assign pready      = 1'b1;
  assign cfg_wr.we   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata;
  assign prdata      = (paddr[2] == REG_INIT_WIN) ? cfg_rd.init_win
                                                  : DATA_BITS'(cfg_rd.mss);

  dctcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dctcp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_rd    (cfg_rd),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted event keeps the input closed in the following cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // The result register is only loaded when its slot is free
  `ASSERT_IMPLIES(a_update_slot_free, clk, rst, cmd.update, status.out_free)
  // The window is never updated while the divider still runs
  `ASSERT_IMPLIES(a_update_div_done, clk, rst, cmd.update, !status.div_busy)
  // The divider is idle whenever a new event can be taken
  `ASSERT_IMPLIES(a_idle_div_quiet, clk, rst, in_ready, !status.div_busy)

endmodule

// ===== dv/cwnd_check_pkg.sv =====
// Window tracker for the congestion window testbench: predicts each result and checks it.
// Depends on dctcp_pkg for the event and result types and the register reset values.
package cwnd_check_pkg;
  import dctcp_pkg::*;

  class cwnd_checker;
    logic [MSS_BITS-1:0]    mss;
    logic [WINDOW_BITS-1:0] win;
    out_t                   predicted_updates[$];
    int                     errors;
    int                     results_checked;
    int                     action_tally[4];

    function new();
      mss = MSS_RESET;
      win = WINDOW_BITS'(INIT_WIN_RESET);
    endfunction

    function void set_mss(logic [MSS_BITS-1:0] value);
      mss = value;
    endfunction

    // Writing the initial window also reloads the live window
    function void load_initial_window(logic [DATA_BITS-1:0] value);
      win = WINDOW_BITS'(value);
    endfunction

    function int pending();
      return predicted_updates.size();
    endfunction

    // Subtract without wrapping, then hold the window at or above mss
    function logic [WINDOW_BITS-1:0] cut_to_floor(logic [WINDOW_BITS-1:0] w,
                                                  logic [BYTES_BITS-1:0] amount);
      logic [WINDOW_BITS-1:0] diff;
      diff = (w > amount) ? w - amount : '0;
      return (diff < WINDOW_BITS'(mss)) ? WINDOW_BITS'(mss) : diff;
    endfunction

    // Advance the window by one event and return the result it produces
    function out_t apply_event(in_t ev);
      logic [63:0] inc;
      logic [63:0] room;
      logic [63:0] grown;
      out_t        res;
      if (ev.has_nack) begin
        win = cut_to_floor(win, ev.nacked_bytes);
        res.action = ACT_NACK;
      end else if (ev.has_ack) begin
        if (ev.ecn_count == '0) begin
          inc = (64'(ev.acked_bytes) * 64'(mss)) / 64'((win == '0) ? 1 : win);
          room = 64'(WIN_MAX - win);
          grown = (inc > room) ? 64'(WIN_MAX) : 64'(win) + inc;
          win = (grown < 64'(mss)) ? WINDOW_BITS'(mss) : grown[WINDOW_BITS-1:0];
          res.action = ACT_INC;
        end else begin
          win = cut_to_floor(win, ev.acked_bytes / 3);
          res.action = ACT_ECN;
        end
      end else begin
        res.action = ACT_NONE;
      end
      res.window_bytes = win;
      return res;
    endfunction

    // Note an accepted event transfer
    function void note_event(in_t ev);
      out_t res;
      res = apply_event(ev);
      action_tally[int'(res.action)]++;
      predicted_updates.push_back(res);
    endfunction

    // Compare a result transfer with the oldest prediction
    function void check_result(out_t got);
      out_t want;
      results_checked++;
      if (predicted_updates.size() == 0) begin
        $error("unexpected result: window_bytes %0d action %0d",
               got.window_bytes, got.action);
        errors++;
        return;
      end
      want = predicted_updates.pop_front();
      if (got.window_bytes !== want.window_bytes) begin
        $error("window_bytes: expected %0d, actual %0d", want.window_bytes, got.window_bytes);
        errors++;
      end
      if (got.action !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, got.action);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== dv/dctcp_window_update_core_tb.sv =====
// Testbench of the congestion window block: directed and random event streams
// under several register settings. Depends on dctcp_pkg and cwnd_check_pkg.
module dctcp_window_update_core_tb;
  import dctcp_pkg::*;
  import cwnd_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_BITS-1:0] MSS_ADDR      = {REG_MSS, 2'b00};
  localparam logic [ADDR_BITS-1:0] INIT_WIN_ADDR = {REG_INIT_WIN, 2'b00};
  localparam int N_SETTINGS      = 9;
  localparam int EVENTS_PER_SET  = 170;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;

  cwnd_checker chk = new();
  bit          steady_src;
  bit          steady_sink;
  int          sink_stall = 0;
  int          quiet_cycles = 0;
  int          events_sent = 0;

  dctcp_window_update_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 90);
  endfunction

  // Byte counts spread over all magnitudes, all ones now and then
  function automatic logic [BYTES_BITS-1:0] rand_bytes();
    int bits;
    if ($urandom_range(0, 99) < 3) return '1;
    bits = $urandom_range(0, 32);
    if (bits == 32) return $urandom;
    return $urandom & ((32'h1 << bits) - 1);
  endfunction

  function automatic in_t mk_event(logic nack, logic ack, logic [BYTES_BITS-1:0] nacked,
                                   logic [BYTES_BITS-1:0] acked, logic [ECN_BITS-1:0] ecn);
    in_t ev;
    ev.has_nack     = nack;
    ev.has_ack      = ack;
    ev.nacked_bytes = nacked;
    ev.acked_bytes  = acked;
    ev.ecn_count    = ecn;
    return ev;
  endfunction

  // Mostly ACKs, with NACKs, both flags and empty events mixed in
  function automatic in_t random_event();
    int                  r;
    logic [ECN_BITS-1:0] ecn;
    r = $urandom_range(0, 99);
    ecn = '0;
    if ($urandom_range(0, 99) < 40) begin
      ecn = ECN_BITS'($urandom & ((32'h1 << $urandom_range(1, 16)) - 1));
      if (ecn == '0) ecn = ECN_BITS'(1);
    end
    return mk_event(r >= 10 && r < 33, r >= 25, rand_bytes(), rand_bytes(), ecn);
  endfunction

  // Receiver side: random stalls on out_ready
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
    end else if (!steady_sink && $urandom_range(0, 99) < 15) begin
      sink_stall = rand_gap();
    end
    out_ready <= (sink_stall == 0);
  end

  // Observe transfers on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) chk.note_event(in_data);
    if (!rst && out_valid && out_ready) chk.check_result(out_data);
  end

  // Count cycles without any transfer or register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input bit wr, input logic [ADDR_BITS-1:0] addr,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_register(input logic [ADDR_BITS-1:0] addr,
                                 input logic [DATA_BITS-1:0] want);
    logic [DATA_BITS-1:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) begin
      $error("register at 0x%0h: expected %0h, actual %0h", addr, want, got);
      chk.errors++;
    end
  endtask

  // Write both registers, read them back and update the tracker
  task automatic program_window(input logic [MSS_BITS-1:0] mss,
                                input logic [DATA_BITS-1:0] init_win);
    logic [DATA_BITS-1:0] unused;
    apb_access(1'b1, MSS_ADDR, DATA_BITS'(mss), unused);
    chk.set_mss(mss);
    apb_access(1'b1, INIT_WIN_ADDR, init_win, unused);
    chk.load_initial_window(init_win);
    verify_register(MSS_ADDR, DATA_BITS'(mss));
    verify_register(INIT_WIN_ADDR, init_win);
  endtask

  // Present one event and hold it until the transfer
  task automatic send_event(input in_t ev);
    int gap;
    gap = steady_src ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_sent++;
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Edge cases under the reset settings (mss 4096, window 65536)
  task automatic run_directed();
    send_event(mk_event(1'b0, 1'b0, $urandom, $urandom, '0));
    send_event(mk_event(1'b0, 1'b1, '0, '0, '0));
    send_event(mk_event(1'b0, 1'b1, '0, BYTES_BITS'(65536), '0));
    send_event(mk_event(1'b0, 1'b1, '0, '1, '0));
    send_event(mk_event(1'b0, 1'b1, '0, '1, '1));
    send_event(mk_event(1'b0, 1'b1, '0, BYTES_BITS'(2), ECN_BITS'(1)));
    send_event(mk_event(1'b1, 1'b0, '0, '0, '0));
    send_event(mk_event(1'b1, 1'b0, '1, '0, '0));
    send_event(mk_event(1'b1, 1'b1, '0, '1, '0));
    send_event(mk_event(1'b1, 1'b1, BYTES_BITS'(100), BYTES_BITS'(5000), ECN_BITS'(7)));
    // Growth from the floor overflows and saturates
    send_event(mk_event(1'b0, 1'b1, '0, '1, '0));
    send_event(mk_event(1'b0, 1'b1, '0, BYTES_BITS'(1), '0));
    send_event(mk_event(1'b0, 1'b1, '0, '1, '0));
    send_event(mk_event(1'b1, 1'b0, 32'hFFFF_FFFF - 32'd8191, '0, '0));
    // ECN cut lands exactly on the floor, then a NACK just below it
    send_event(mk_event(1'b0, 1'b1, '0, BYTES_BITS'(3 * 4095), 16'h8000));
    send_event(mk_event(1'b1, 1'b0, BYTES_BITS'(1), '0, '0));
    send_event(mk_event(1'b0, 1'b0, '1, '1, '1));
  endtask

  initial begin
    logic [MSS_BITS-1:0]  mss;
    logic [DATA_BITS-1:0] init_win;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    verify_register(MSS_ADDR, DATA_BITS'(MSS_RESET));
    verify_register(INIT_WIN_ADDR, INIT_WIN_RESET);

    for (int s = 0; s < N_SETTINGS; s++) begin
      // Extremes first, then random settings
      case (s)
        0: ;
        1: program_window(MSS_BITS'(1), DATA_BITS'(1));
        2: program_window('1, '1);
        3: program_window('1, DATA_BITS'(1));
        4: program_window(MSS_BITS'(1), '1);
        default: begin
          mss = MSS_BITS'($urandom_range(1, (1 << $urandom_range(1, 16)) - 1));
          init_win = rand_bytes();
          if (init_win == '0) init_win = DATA_BITS'(1);
          program_window(mss, init_win);
        end
      endcase
      if (s == 0) run_directed();
      for (int i = 0; i < EVENTS_PER_SET; i++) begin
        if (i % 40 == 0) begin
          steady_src  = ($urandom_range(0, 3) == 0);
          steady_sink = ($urandom_range(0, 3) == 0);
        end
        send_event(random_event());
      end
      drain();
    end

    $display("covered %0d events over %0d register settings, %0d results checked",
             events_sent, N_SETTINGS, chk.results_checked);
    $display("actions: %0d none, %0d nack cuts, %0d increases, %0d ecn cuts",
             chk.action_tally[ACT_NONE], chk.action_tally[ACT_NACK],
             chk.action_tally[ACT_INC], chk.action_tally[ACT_ECN]);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== dctcp_window_update_core.f =====
+incdir+sv
sv/dctcp_pkg.sv
sv/dctcp_div.sv
sv/dctcp_dp.sv
sv/dctcp_ctrl.sv
sv/dctcp_window_update_core.sv
dv/cwnd_check_pkg.sv
dv/dctcp_window_update_core_tb.sv
